[hw/rtl/plc_pkg.sv]
// Shared types and constants for the password lock controller.
`default_nettype none

package plc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOCKW,
        PH_OP,
        PH_SET,
        PH_OLD,
        PH_NEW,
        PH_ENTRY
    } phase_t;

    typedef logic [3:0] event_t;

    localparam event_t EV_IGNORED      = 4'd0;
    localparam event_t EV_AWAIT_OP     = 4'd1;
    localparam event_t EV_CHAR_TAKEN   = 4'd2;
    localparam event_t EV_PASS_SET     = 4'd3;
    localparam event_t EV_OLD_WRONG    = 4'd4;
    localparam event_t EV_OLD_RIGHT    = 4'd5;
    localparam event_t EV_NEW_SET      = 4'd6;
    localparam event_t EV_OPENED       = 4'd7;
    localparam event_t EV_WRONG_RETRY  = 4'd8;
    localparam event_t EV_LOCKED_NOW   = 4'd9;
    localparam event_t EV_LOCKED_START = 4'd10;
    localparam event_t EV_LOCK_CLEARED = 4'd11;

    localparam logic       REQ_START  = 1'b0;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [2:0] TRIES_MAX  = 3'd7;
    localparam logic [2:0] TRIES_RST  = 3'd3;

endpackage

`default_nettype wire

[hw/rtl/plc_match.sv]
// Compares the entry buffer, with the incoming character at its slot, against the password.
`default_nettype none

module plc_match #(
    parameter int PASS_LEN = 4,
    parameter int IDX_W    = 2
) (
    input  wire logic [PASS_LEN-1:0][7:0] entry,
    input  wire logic [PASS_LEN-1:0][7:0] stored,
    input  wire logic [IDX_W-1:0]         idx,
    input  wire logic [7:0]               char_in,
    output      logic                     match
);

    always_comb
    begin
        logic       all_eq;
        logic [7:0] cur;
        all_eq = 1'b1;
        for (int i = 0; i < PASS_LEN; i++)
        begin
            cur = (IDX_W'(i) == idx) ? char_in : entry[i];
            if (cur != stored[i])
            begin
                all_eq = 1'b0;
            end
        end
        match = all_eq;
    end

endmodule

`default_nettype wire

[hw/rtl/password_lock_controller.sv]
// Password lock controller top level: input register, step logic, result register.
// An input transaction is captured in the input register, and its result is captured in the
// result register, where out_valid rises.
// Throughput: one transaction per cycle while the result is not stalled; the compare over all password characters
// and the phase update finish in the single step stage. A stalled result holds the input.
// Reset: phase idle, password all zeros, lock flag and tries cleared, try limit 3.
`default_nettype none

module password_lock_controller #(
    parameter int PASS_LEN = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output      logic       cfg_ready,
    input  wire logic [2:0] cfg_data,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire logic       req_type,
    input  wire logic [7:0] char_code,
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      logic [3:0] event_code,
    output      logic [2:0] tries_left,
    output      logic       door_open,
    output      logic       alarm_on
);

    import plc_pkg::*;

    localparam int IDX_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PASS_LEN - 1);

    // configuration
    logic [2:0] try_limit_reg;

    // input stage
    logic       in_valid_reg;
    logic       req_type_reg;
    logic [7:0] char_reg;

    // lock state
    phase_t                   phase_reg, phase_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [2:0]               tries_reg, tries_next;
    logic                     lock_reg, lock_next;
    logic [PASS_LEN-1:0][7:0] entry_reg;
    logic [PASS_LEN-1:0][7:0] pass_reg;

    // result stage
    logic       out_valid_reg;
    event_t     event_reg, event_next;
    logic [2:0] left_reg, left_next;
    logic       door_reg, door_next;
    logic       alarm_reg, alarm_next;

    logic proc;
    logic last;
    logic match;

    assign cfg_ready = 1'b1;
    assign proc      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || proc;
    assign last      = (idx_reg == IDX_LAST);

    plc_match #(
        .PASS_LEN (PASS_LEN),
        .IDX_W    (IDX_W)
    ) u_match (
        .entry   (entry_reg),
        .stored  (pass_reg),
        .idx     (idx_reg),
        .char_in (char_reg),
        .match   (match)
    );

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        tries_next = tries_reg;
        lock_next  = lock_reg;
        if (req_type_reg == REQ_START)
        begin
            idx_next   = '0;
            tries_next = '0;
            phase_next = lock_reg ? PH_LOCKW : PH_OP;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_LOCKW:
                begin
                    if (char_reg == CHAR_ZERO)
                    begin
                        lock_next = 1'b0;
                    end
                    phase_next = PH_IDLE;
                end
                PH_OP:
                begin
                    idx_next = '0;
                    if (char_reg == CHAR_ZERO)
                    begin
                        phase_next = PH_SET;
                    end
                    else if (char_reg == CHAR_TWO)
                    begin
                        phase_next = PH_OLD;
                    end
                    else
                    begin
                        phase_next = PH_ENTRY;
                    end
                end
                PH_SET, PH_NEW:
                begin
                    idx_next = last ? '0 : idx_reg + 1'b1;
                    if (last)
                    begin
                        phase_next = PH_ENTRY;
                    end
                end
                PH_OLD:
                begin
                    idx_next = last ? '0 : idx_reg + 1'b1;
                    if (last && match)
                    begin
                        phase_next = PH_NEW;
                    end
                end
                PH_ENTRY:
                begin
                    idx_next = last ? '0 : idx_reg + 1'b1;
                    if (last)
                    begin
                        if (match)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            if (tries_reg != TRIES_MAX)
                            begin
                                tries_next = tries_reg + 3'd1;
                            end
                            // saturated count reaching the limit ends the session
                            if (!((tries_reg != TRIES_MAX ? tries_reg + 3'd1 : tries_reg)
                                  < try_limit_reg))
                            begin
                                lock_next  = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result fields
    always_comb
    begin
        event_next = EV_IGNORED;
        door_next  = 1'b0;
        alarm_next = 1'b0;
        if (req_type_reg == REQ_START)
        begin
            event_next = lock_reg ? EV_LOCKED_START : EV_AWAIT_OP;
        end
        else
        begin
            case (phase_reg)
                PH_LOCKW:
                begin
                    event_next = (char_reg == CHAR_ZERO) ? EV_LOCK_CLEARED : EV_IGNORED;
                end
                PH_OP:
                begin
                    event_next = EV_CHAR_TAKEN;
                end
                PH_SET:
                begin
                    event_next = last ? EV_PASS_SET : EV_CHAR_TAKEN;
                end
                PH_NEW:
                begin
                    event_next = last ? EV_NEW_SET : EV_CHAR_TAKEN;
                end
                PH_OLD:
                begin
                    if (!last)
                    begin
                        event_next = EV_CHAR_TAKEN;
                    end
                    else
                    begin
                        event_next = match ? EV_OLD_RIGHT : EV_OLD_WRONG;
                    end
                end
                PH_ENTRY:
                begin
                    if (!last)
                    begin
                        event_next = EV_CHAR_TAKEN;
                    end
                    else if (match)
                    begin
                        event_next = EV_OPENED;
                        door_next  = 1'b1;
                    end
                    else if (lock_next)
                    begin
                        event_next = EV_LOCKED_NOW;
                        alarm_next = 1'b1;
                    end
                    else
                    begin
                        event_next = EV_WRONG_RETRY;
                    end
                end
                default:
                begin
                    event_next = EV_IGNORED;
                end
            endcase
        end
        left_next = (try_limit_reg > tries_next) ? try_limit_reg - tries_next : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            try_limit_reg <= TRIES_RST;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            idx_reg       <= '0;
            tries_reg     <= '0;
            lock_reg      <= 1'b0;
            pass_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                try_limit_reg <= cfg_data;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (proc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                tries_reg <= tries_next;
                lock_reg  <= lock_next;
                if (req_type_reg != REQ_START &&
                    (phase_reg == PH_SET || phase_reg == PH_NEW))
                begin
                    pass_reg[idx_reg] <= char_reg;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_type_reg <= req_type;
            char_reg     <= char_code;
        end
        if (proc)
        begin
            event_reg <= event_next;
            left_reg  <= left_next;
            door_reg  <= door_next;
            alarm_reg <= alarm_next;
            if (req_type_reg != REQ_START &&
                (phase_reg == PH_OLD || phase_reg == PH_ENTRY))
            begin
                entry_reg[idx_reg] <= char_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_reg;
    assign tries_left = left_reg;
    assign door_open  = door_reg;
    assign alarm_on   = alarm_reg;

endmodule

`default_nettype wire
